@@ src/ellipse_rasterizer_top_assert.svh @@
// assertion macros shared by the ellipse rasterizer modules
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef ELLIPSE_RASTERIZER_TOP_ASSERT_SVH
`define ELLIPSE_RASTERIZER_TOP_ASSERT_SVH
`ifndef SYNTH
// property holds at every edge outside reset
`define ELR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("elr assertion failed");
// pre at one edge implies post at the next edge
`define ELR_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("elr assertion failed");
`else
`define ELR_ASSERT(lbl, prop)
`define ELR_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

@@ src/elr_pkg.sv @@
// shared constants and types for the ellipse rasterizer
// no dependencies
package elr_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int COLOR_BITS     = 24;

  // walk region codes
  localparam logic [1:0] REG_IDLE = 2'd0;
  localparam logic [1:0] REG_ONE  = 2'd1;
  localparam logic [1:0] REG_TWO  = 2'd2;

  // input word kinds
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // core to emitter handoff
  typedef struct packed {
    logic load;
    logic done;
  } elr_ctl_t;

endpackage

@@ src/ellipse_rasterizer_top.sv @@
// ellipse rasterizer top level: input word register, walk core and pixel emitter
// depends on elr_pkg, elr_core, elr_emit
//
//  channel | dir | tdata (low bit first)                        | tuser    | tlast
//  --------+-----+----------------------------------------------+----------+-----------
//  in_     | in  | center_x, center_y, radius_x, radius_y, color | action   | -
//  out_    | out | pixel_x, pixel_y, pixel_color                 | done_res | last pixel
//
//  a step word while walking gives four pixel words, one per cycle while out_tready is high,
//  so a walk is paced by the single pixel port
//  a start word first registers the squared semi-axes, then builds both region
//  decision seeds from them; a step while idle is consumed without giving pixels
//  the next word is taken into the input register while pixels still drain
//  reset (rst_n low, synchronous) empties both registers and idles the walk
//  a stall on out_ holds the pixel word and, after one buffered word, in_tready
module ellipse_rasterizer_top #(
  parameter  int COORD_BITS = elr_pkg::COORD_BITS_DEF,
  localparam int IN_BITS    = 2 * COORD_BITS + 2 * (COORD_BITS - 1) + elr_pkg::COLOR_BITS,
  localparam int IN_DW      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS   = 2 * (COORD_BITS + 2) + elr_pkg::COLOR_BITS,
  localparam int OUT_DW     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // center_x, center_y, radius_x, radius_y, pen_color
  input  logic              in_tuser,   // action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // pixel_x, pixel_y, pixel_color
  output logic              out_tuser,  // done_res
  output logic              out_tlast
);
  import elr_pkg::*;

  localparam int CB      = COORD_BITS;
  localparam int RW      = CB - 1;
  localparam int PW      = CB + 2;
  localparam int OFF_CY  = CB;
  localparam int OFF_RX  = 2 * CB;
  localparam int OFF_RY  = 3 * CB - 1;
  localparam int OFF_COL = 4 * CB - 2;

  // input word register, acts as the skid stage in front of the core
  logic                   in_vld_r, in_vld_nxt;
  logic                   in_act_r;
  logic [CB-1:0]          in_cx_r, in_cy_r;
  logic [RW-1:0]          in_rx_r, in_ry_r;
  logic [COLOR_BITS-1:0]  in_color_r;

  logic                   consume;
  logic                   emit_free;
  elr_ctl_t               ctl;
  logic signed [PW-1:0]   px_p, px_m, py_p, py_m;
  logic [COLOR_BITS-1:0]  core_color;
  logic signed [PW-1:0]   pix_x, pix_y;
  logic [COLOR_BITS-1:0]  pix_color;

  assign in_tready = !in_vld_r || consume;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end else if (consume) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_act_r   <= in_tuser;
      in_cx_r    <= in_tdata[0 +: CB];
      in_cy_r    <= in_tdata[OFF_CY +: CB];
      in_rx_r    <= in_tdata[OFF_RX +: RW];
      in_ry_r    <= in_tdata[OFF_RY +: RW];
      in_color_r <= in_tdata[OFF_COL +: COLOR_BITS];
    end
  end

  // walk state and one-step arithmetic
  elr_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld_r),
    .in_act    (in_act_r),
    .in_cx     (in_cx_r),
    .in_cy     (in_cy_r),
    .in_rx     (in_rx_r),
    .in_ry     (in_ry_r),
    .in_color  (in_color_r),
    .emit_free (emit_free),
    .consume   (consume),
    .ctl       (ctl),
    .px_p      (px_p),
    .px_m      (px_m),
    .py_p      (py_p),
    .py_m      (py_m),
    .color     (core_color)
  );

  // result register, sends the four mirrored pixels
  elr_emit #(
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .px_p       (px_p),
    .px_m       (px_m),
    .py_p       (py_p),
    .py_m       (py_m),
    .color      (core_color),
    .out_tready (out_tready),
    .free       (emit_free),
    .out_tvalid (out_tvalid),
    .out_tlast  (out_tlast),
    .out_done   (out_tuser),
    .pix_x      (pix_x),
    .pix_y      (pix_y),
    .pix_color  (pix_color)
  );

  // zero-fill up to whole bytes
  assign out_tdata = OUT_DW'({pix_color, pix_y, pix_x});

endmodule

@@ src/elr_core.sv @@
// midpoint ellipse walk: held shape, region state, decision term and one-step datapath
// depends on elr_pkg and ellipse_rasterizer_top_assert.svh
`include "ellipse_rasterizer_top_assert.svh"

module elr_core #(
  parameter int COORD_BITS = elr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_vld,
  input  logic                              in_act,
  input  logic [COORD_BITS-1:0]             in_cx,
  input  logic [COORD_BITS-1:0]             in_cy,
  input  logic [COORD_BITS-2:0]             in_rx,
  input  logic [COORD_BITS-2:0]             in_ry,
  input  logic [elr_pkg::COLOR_BITS-1:0]    in_color,
  input  logic                              emit_free,
  output logic                              consume,
  output elr_pkg::elr_ctl_t                 ctl,
  output logic signed [COORD_BITS+1:0]      px_p,
  output logic signed [COORD_BITS+1:0]      px_m,
  output logic signed [COORD_BITS+1:0]      py_p,
  output logic signed [COORD_BITS+1:0]      py_m,
  output logic [elr_pkg::COLOR_BITS-1:0]    color
);
  import elr_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int RW = CB - 1;
  localparam int AW = 2 * RW;
  localparam int WW = CB + 1;
  localparam int DW = 3 * CB + 4;
  localparam int PW = CB + 2;

  logic [1:0]             region_r, region_nxt;
  logic                   pend_r, pend_nxt;
  logic [CB-1:0]          cx_r, cy_r;
  logic [RW-1:0]          rx_r, ry_r;
  logic [COLOR_BITS-1:0]  color_r;
  logic [AW-1:0]          a_r, b_r;
  logic signed [DW-1:0]   d_r, d2_r;
  logic signed [WW-1:0]   x_r, y_r;

  logic                   is_start, active, take_start, do_step;
  logic                   r_one, dge, point, go_on, leave;
  logic signed [AW:0]     a_sx, b_sx, p_s, q_s;
  logic signed [CB:0]     k1, k2;
  logic signed [DW-1:0]   mul_ak1, mul_bk2, seed1, seed2;
  logic signed [WW-1:0]   u, v;
  logic signed [WW:0]     one_mv, u1, v1;
  logic signed [WW+2:0]   four_u6;
  logic signed [DW-1:0]   mul_q, mul_p, term_a, d_step, lhs, rhs;
  logic signed [PW-1:0]   cx_e, cy_e, x_e, y_e;

  assign is_start   = (in_act == ACT_START);
  assign active     = (region_r != REG_IDLE);
  assign consume    = in_vld && !pend_r && (is_start || !active || emit_free);
  assign take_start = consume && is_start;
  assign do_step    = consume && !is_start && active;

  // decision seeds for both regions, loaded in the cycle after a start
  assign a_sx    = {1'b0, a_r};
  assign b_sx    = {1'b0, b_r};
  assign k1      = (CB+1)'(1) - {1'b0, ry_r, 1'b0};
  assign k2      = (CB+1)'(1) - {1'b0, rx_r, 1'b0};
  assign mul_ak1 = a_sx * k1;
  assign mul_bk2 = b_sx * k2;
  assign seed1   = (DW'(b_sx) <<< 1) + mul_ak1;
  assign seed2   = (DW'(a_sx) <<< 1) + mul_bk2;

  // both regions share one datapath with the axes swapped in region two
  assign r_one   = (region_r == REG_ONE);
  assign p_s     = r_one ? b_sx : a_sx;
  assign q_s     = r_one ? a_sx : b_sx;
  assign u       = r_one ? x_r : y_r;
  assign v       = r_one ? y_r : x_r;
  assign dge     = ~d_r[DW-1];
  assign one_mv  = (WW+1)'(1) - {v[WW-1], v};
  assign four_u6 = {u[WW-1], u, 2'b00} + (WW+3)'(6);
  assign mul_q   = q_s * one_mv;
  assign mul_p   = p_s * four_u6;
  assign term_a  = dge ? (mul_q <<< 2) : '0;
  assign d_step  = d_r + term_a + mul_p;
  assign u1      = {u[WW-1], u} + (WW+1)'(1);
  assign v1      = {v[WW-1], v} - (WW+1)'(dge);
  assign lhs     = p_s * u1;
  assign rhs     = q_s * v1;
  assign go_on   = (lhs <= rhs);
  assign point   = (rx_r == '0) && (ry_r == '0);
  assign leave   = point || !go_on;

  assign ctl.load = do_step;
  assign ctl.done = !r_one && leave;

  // mirrored coordinates of the current walk point
  assign cx_e  = {2'b00, cx_r};
  assign cy_e  = {2'b00, cy_r};
  assign x_e   = {x_r[WW-1], x_r};
  assign y_e   = {y_r[WW-1], y_r};
  assign px_p  = cx_e + x_e;
  assign px_m  = cx_e - x_e;
  assign py_p  = cy_e + y_e;
  assign py_m  = cy_e - y_e;
  assign color = color_r;

  always_comb begin
    region_nxt = region_r;
    pend_nxt   = 1'b0;
    if (take_start) begin
      region_nxt = REG_ONE;
      pend_nxt   = 1'b1;
    end else if (do_step && leave) begin
      region_nxt = r_one ? REG_TWO : REG_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r <= REG_IDLE;
      pend_r   <= 1'b0;
    end else begin
      region_r <= region_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_start) begin
      cx_r    <= in_cx;
      cy_r    <= in_cy;
      rx_r    <= in_rx;
      ry_r    <= in_ry;
      color_r <= in_color;
      a_r     <= AW'(in_rx) * AW'(in_rx);
      b_r     <= AW'(in_ry) * AW'(in_ry);
      x_r     <= '0;
      y_r     <= WW'(in_ry);
    end else if (pend_r) begin
      d_r  <= seed1;
      d2_r <= seed2;
    end else if (do_step) begin
      if (r_one && leave) begin
        x_r <= WW'(rx_r);
        y_r <= '0;
        d_r <= d2_r;
      end else begin
        x_r <= r_one ? u1[WW-1:0] : v1[WW-1:0];
        y_r <= r_one ? v1[WW-1:0] : u1[WW-1:0];
        d_r <= d_step;
      end
    end
  end

  `ELR_ASSERT(a_no_take_in_seed, pend_r |-> !consume)
  `ELR_ASSERT_NEXT(a_seed_after_start, take_start, pend_r)
  `ELR_ASSERT_NEXT(a_idle_after_done, (ctl.load && ctl.done), (region_r == REG_IDLE))

endmodule

@@ src/elr_emit.sv @@
// four-beat emitter: holds a step's mirrored pixels, sends one per cycle while out_tready
// depends on elr_pkg and ellipse_rasterizer_top_assert.svh
`include "ellipse_rasterizer_top_assert.svh"

module elr_emit #(
  parameter int COORD_BITS = elr_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  elr_pkg::elr_ctl_t                 ctl,
  input  logic signed [COORD_BITS+1:0]      px_p,
  input  logic signed [COORD_BITS+1:0]      px_m,
  input  logic signed [COORD_BITS+1:0]      py_p,
  input  logic signed [COORD_BITS+1:0]      py_m,
  input  logic [elr_pkg::COLOR_BITS-1:0]    color,
  input  logic                              out_tready,
  output logic                              free,
  output logic                              out_tvalid,
  output logic                              out_tlast,
  output logic                              out_done,
  output logic signed [COORD_BITS+1:0]      pix_x,
  output logic signed [COORD_BITS+1:0]      pix_y,
  output logic [elr_pkg::COLOR_BITS-1:0]    pix_color
);
  import elr_pkg::*;

  localparam int PW = COORD_BITS + 2;
  localparam logic [1:0] BEAT_LAST = 2'd3;

  logic                   vld_r, vld_nxt;
  logic [1:0]             beat_r, beat_nxt;
  logic signed [PW-1:0]   pxp_r, pxm_r, pyp_r, pym_r;
  logic [COLOR_BITS-1:0]  color_r;
  logic                   done_r;

  assign free = !vld_r || (out_tready && (beat_r == BEAT_LAST));

  // order: (+x,+y) (-x,+y) (+x,-y) (-x,-y)
  assign out_tvalid = vld_r;
  assign out_tlast  = (beat_r == BEAT_LAST);
  assign out_done   = done_r;
  assign pix_x      = beat_r[0] ? pxm_r : pxp_r;
  assign pix_y      = beat_r[1] ? pym_r : pyp_r;
  assign pix_color  = color_r;

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (ctl.load) begin
      vld_nxt  = 1'b1;
      beat_nxt = '0;
    end else if (vld_r && out_tready) begin
      beat_nxt = beat_r + 2'd1;
      if (beat_r == BEAT_LAST) begin
        vld_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pxp_r   <= px_p;
      pxm_r   <= px_m;
      pyp_r   <= py_p;
      pym_r   <= py_m;
      color_r <= color;
      done_r  <= ctl.done;
    end
  end

  `ELR_ASSERT(a_load_when_free, ctl.load |-> free)
  `ELR_ASSERT_NEXT(a_drain_after_last, (out_tvalid && out_tready && out_tlast && !ctl.load),
                   !out_tvalid)
  `ELR_ASSERT_NEXT(a_done_whole_run, (out_tvalid && out_tready && !out_tlast),
                   (out_done == $past(out_done)))

endmodule
